// File: rtl/modular_square_root_assert.svh
// -----------------------------------------------------------------------------
// Assertion macros for the modular square root block
// Shared property forms used by the port checker.
// -----------------------------------------------------------------------------
`ifndef MODULAR_SQUARE_ROOT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSQRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modular_square_root: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSQRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modular_square_root: next-cycle check failed");

`endif

// File: rtl/msqrt_pkg.sv
// -----------------------------------------------------------------------------
// msqrt_pkg
// Types, constants and command encodings shared by the modular square root.
// -----------------------------------------------------------------------------
package msqrt_pkg;

    localparam int FIELD_BITS      = 32;
    localparam int WORD_BITS       = 32;
    localparam int CNT_BITS        = $clog2(WORD_BITS + 1);
    localparam int NR_SEARCH_LIMIT = 4096;
    localparam int TRY_BITS        = $clog2(NR_SEARCH_LIMIT + 1);
    // The candidate non-residue never exceeds the search limit plus two.
    localparam int Z_BITS          = $clog2(NR_SEARCH_LIMIT + 3);
    localparam int RED_BITS        = (WORD_BITS > Z_BITS) ? WORD_BITS : Z_BITS;
    localparam int RED_CNT_BITS    = $clog2(RED_BITS + 1);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic [FIELD_BITS-1:0] modulus;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] root;
        logic                  is_residue;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RED_A,
        OP_RED_Z,
        OP_POW_INIT,
        OP_POW_SHIFT,
        OP_MUL,
        OP_Q_INIT,
        OP_Q_SHIFT,
        OP_Z_INIT,
        OP_Z_NEXT,
        OP_SAVE,
        OP_M_FROM_S,
        OP_TT_INIT,
        OP_I_INC,
        OP_B_INIT,
        OP_J_INC,
        OP_M_SET,
        OP_RESULT
    } dp_op_t;

    typedef enum logic [2:0] {
        SEL_ACC,
        SEL_BASE,
        SEL_TT,
        SEL_B,
        SEL_C,
        SEL_T,
        SEL_ROOT
    } reg_sel_t;

    typedef enum logic {
        BASE_R,
        BASE_Z
    } base_sel_t;

    typedef enum logic [1:0] {
        EXP_HALF,
        EXP_P34,
        EXP_Q,
        EXP_Q1
    } exp_sel_t;

    typedef enum logic [2:0] {
        RES_ZERO_NO,
        RES_ZERO_YES,
        RES_LOWBIT,
        RES_ACC,
        RES_ROOT
    } res_sel_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_CHECK_P,
        S_RED_A_W,
        S_CHECK_R,
        S_POW,
        S_POW_MW,
        S_POW_SQ,
        S_POW_SW,
        S_EULER,
        S_FIN_ACC,
        S_QLOOP,
        S_ZTRY,
        S_ZRED,
        S_ZPOW,
        S_ZCHK,
        S_SAVE_C,
        S_TPOW,
        S_SAVE_T,
        S_RPOW,
        S_SAVE_ROOT,
        S_TS_INIT,
        S_TS_LOOP,
        S_ORD,
        S_ORD_W,
        S_BSQ,
        S_BSQ_W,
        S_C_SQ,
        S_C_W,
        S_T_MUL,
        S_T_W,
        S_R_MUL,
        S_R_W,
        S_RESULT
    } state_t;

    typedef struct packed {
        dp_op_t    op;
        reg_sel_t  mul_x;
        reg_sel_t  mul_y;
        reg_sel_t  dst;
        base_sel_t pow_base;
        exp_sel_t  pow_exp;
        res_sel_t  res;
    } cmd_t;

    typedef struct packed {
        logic p_zero;
        logic p_two;
        logic p_mod4_3;
        logic r_zero;
        logic red_done;
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
        logic acc_one;
        logic acc_pm1;
        logic q_even;
        logic tries_max;
        logic t_one;
        logic tt_one;
        logic i_lt_m;
        logic j_lt_m;
        logic out_busy;
    } status_t;

endpackage

// File: rtl/msqrt_mulmod.sv
// -----------------------------------------------------------------------------
// msqrt_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, add and double.
// -----------------------------------------------------------------------------
module msqrt_mulmod
    import msqrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t x,
    input  word_t y,
    input  word_t p,
    output logic  done,
    output word_t prod
);

    logic  busy_reg;
    logic  done_reg;
    word_t x_reg;
    word_t y_reg;
    word_t acc_reg;

    // Both operands are below the modulus, so one conditional subtract suffices.
    function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (y_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= '0;
        end
        else if (busy_reg && (y_reg != '0))
        begin
            if (y_reg[0])
            begin
                acc_reg <= add_mod(acc_reg, x_reg, p);
            end
            x_reg <= add_mod(x_reg, x_reg, p);
            y_reg <= y_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: rtl/msqrt_reduce.sv
// -----------------------------------------------------------------------------
// msqrt_reduce
// Restoring remainder unit: one dividend bit per cycle.
// -----------------------------------------------------------------------------
module msqrt_reduce
    import msqrt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RED_BITS-1:0] dividend,
    input  word_t               p,
    output logic                done,
    output word_t               rem
);

    logic                    busy_reg;
    logic                    done_reg;
    logic [RED_CNT_BITS-1:0] cnt_reg;
    logic [RED_BITS-1:0]     div_reg;
    word_t                   rem_reg;
    logic [WORD_BITS:0]      trial;

    // The partial remainder stays below p, so the shifted value is below 2p.
    always_comb
    begin
        trial = {rem_reg, div_reg[RED_BITS-1]};
        if (trial >= {1'b0, p})
        begin
            trial = trial - {1'b0, p};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= RED_CNT_BITS'(RED_BITS);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= trial[WORD_BITS-1:0];
            div_reg <= div_reg << 1;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/msqrt_datapath.sv
// -----------------------------------------------------------------------------
// msqrt_datapath
// Working registers, the shared multiplier and remainder units, result register.
// -----------------------------------------------------------------------------
module msqrt_datapath
    import msqrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  req_t    req,
    input  logic    rsp_stall,
    output status_t status,
    output rsp_t    rsp,
    output logic    rsp_valid
);

    word_t               a_reg;
    word_t               p_reg;
    word_t               r_reg;
    word_t               zred_reg;
    word_t               acc_reg;
    word_t               base_reg;
    word_t               e_reg;
    word_t               q_reg;
    word_t               c_reg;
    word_t               t_reg;
    word_t               root_reg;
    word_t               tt_reg;
    word_t               b_reg;
    logic [CNT_BITS-1:0] s_reg;
    logic [CNT_BITS-1:0] m_reg;
    logic [CNT_BITS-1:0] i_reg;
    logic [CNT_BITS-1:0] j_reg;
    logic [Z_BITS-1:0]   z_reg;
    logic [TRY_BITS-1:0] tries_reg;
    reg_sel_t            mul_dst_reg;
    logic                red_to_z_reg;
    rsp_t                rsp_reg;
    logic                rsp_valid_reg;

    logic                mul_start;
    logic                mul_done;
    word_t               mul_x;
    word_t               mul_y;
    word_t               prod;
    logic                red_start;
    logic                red_done;
    logic [RED_BITS-1:0] red_dividend;
    word_t               rem;
    logic [WORD_BITS:0]  q_inc;

    function automatic word_t pick(input reg_sel_t sel, input word_t acc, input word_t base,
                                   input word_t tt, input word_t b, input word_t c,
                                   input word_t t, input word_t root);
        word_t v;
        unique case (sel)
            SEL_ACC:  v = acc;
            SEL_BASE: v = base;
            SEL_TT:   v = tt;
            SEL_B:    v = b;
            SEL_C:    v = c;
            SEL_T:    v = t;
            SEL_ROOT: v = root;
            default:  v = acc;
        endcase
        return v;
    endfunction

    assign mul_start    = (cmd.op == OP_MUL);
    assign mul_x        = pick(cmd.mul_x, acc_reg, base_reg, tt_reg, b_reg, c_reg, t_reg,
                               root_reg);
    assign mul_y        = pick(cmd.mul_y, acc_reg, base_reg, tt_reg, b_reg, c_reg, t_reg,
                               root_reg);
    assign red_start    = (cmd.op == OP_RED_A) || (cmd.op == OP_RED_Z);
    assign red_dividend = (cmd.op == OP_RED_Z) ? RED_BITS'(z_reg) : RED_BITS'(a_reg);
    assign q_inc        = {1'b0, q_reg} + 1'b1;

    msqrt_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .p     (p_reg),
        .done  (mul_done),
        .prod  (prod)
    );

    msqrt_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (red_start),
        .dividend (red_dividend),
        .p        (p_reg),
        .done     (red_done),
        .rem      (rem)
    );

    always_ff @(posedge clk)
    begin
        if (mul_done)
        begin
            unique case (mul_dst_reg)
                SEL_ACC:  acc_reg  <= prod;
                SEL_BASE: base_reg <= prod;
                SEL_TT:   tt_reg   <= prod;
                SEL_B:    b_reg    <= prod;
                SEL_C:    c_reg    <= prod;
                SEL_T:    t_reg    <= prod;
                SEL_ROOT: root_reg <= prod;
                default:  acc_reg  <= prod;
            endcase
        end
        if (red_done)
        begin
            if (red_to_z_reg)
            begin
                zred_reg <= rem;
            end
            else
            begin
                r_reg <= rem;
            end
        end

        unique case (cmd.op)
            OP_LOAD:
            begin
                a_reg <= WORD_BITS'(req.value);
                p_reg <= WORD_BITS'(req.modulus);
            end
            OP_RED_A:
            begin
                red_to_z_reg <= 1'b0;
            end
            OP_RED_Z:
            begin
                red_to_z_reg <= 1'b1;
            end
            OP_POW_INIT:
            begin
                acc_reg  <= word_t'(1);
                base_reg <= (cmd.pow_base == BASE_Z) ? zred_reg : r_reg;
                unique case (cmd.pow_exp)
                    EXP_HALF: e_reg <= (p_reg - 1'b1) >> 1;
                    EXP_P34:  e_reg <= (p_reg >> 2) + 1'b1;
                    EXP_Q:    e_reg <= q_reg;
                    EXP_Q1:   e_reg <= q_inc[WORD_BITS:1];
                    default:  e_reg <= q_reg;
                endcase
            end
            OP_POW_SHIFT:
            begin
                e_reg <= e_reg >> 1;
            end
            OP_MUL:
            begin
                mul_dst_reg <= cmd.dst;
            end
            OP_Q_INIT:
            begin
                q_reg <= p_reg - 1'b1;
                s_reg <= '0;
            end
            OP_Q_SHIFT:
            begin
                q_reg <= q_reg >> 1;
                s_reg <= s_reg + 1'b1;
            end
            OP_Z_INIT:
            begin
                z_reg     <= Z_BITS'(2);
                tries_reg <= '0;
            end
            OP_Z_NEXT:
            begin
                z_reg     <= z_reg + 1'b1;
                tries_reg <= tries_reg + 1'b1;
            end
            OP_SAVE:
            begin
                unique case (cmd.dst)
                    SEL_C:    c_reg    <= acc_reg;
                    SEL_T:    t_reg    <= acc_reg;
                    SEL_ROOT: root_reg <= acc_reg;
                    default:  c_reg    <= acc_reg;
                endcase
            end
            OP_M_FROM_S:
            begin
                m_reg <= s_reg;
            end
            OP_TT_INIT:
            begin
                tt_reg <= t_reg;
                i_reg  <= '0;
            end
            OP_I_INC:
            begin
                i_reg <= i_reg + 1'b1;
            end
            OP_B_INIT:
            begin
                b_reg <= c_reg;
                j_reg <= i_reg + 1'b1;
            end
            OP_J_INC:
            begin
                j_reg <= j_reg + 1'b1;
            end
            OP_M_SET:
            begin
                m_reg <= i_reg;
            end
            OP_RESULT:
            begin
                unique case (cmd.res)
                    RES_ZERO_NO:
                    begin
                        rsp_reg.root       <= '0;
                        rsp_reg.is_residue <= 1'b0;
                    end
                    RES_ZERO_YES:
                    begin
                        rsp_reg.root       <= '0;
                        rsp_reg.is_residue <= 1'b1;
                    end
                    RES_LOWBIT:
                    begin
                        rsp_reg.root       <= FIELD_BITS'(r_reg[0]);
                        rsp_reg.is_residue <= 1'b1;
                    end
                    RES_ACC:
                    begin
                        rsp_reg.root       <= FIELD_BITS'(acc_reg);
                        rsp_reg.is_residue <= 1'b1;
                    end
                    RES_ROOT:
                    begin
                        rsp_reg.root       <= FIELD_BITS'(root_reg);
                        rsp_reg.is_residue <= 1'b1;
                    end
                    default:
                    begin
                        rsp_reg.root       <= '0;
                        rsp_reg.is_residue <= 1'b0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_RESULT)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        status.p_zero    = (p_reg == '0);
        status.p_two     = (p_reg == word_t'(2));
        status.p_mod4_3  = (p_reg[1:0] == 2'b11);
        status.r_zero    = (r_reg == '0);
        status.red_done  = red_done;
        status.mul_done  = mul_done;
        status.exp_zero  = (e_reg == '0);
        status.exp_lsb   = e_reg[0];
        status.acc_one   = (acc_reg == word_t'(1));
        status.acc_pm1   = (acc_reg == (p_reg - 1'b1));
        status.q_even    = !q_reg[0];
        status.tries_max = (tries_reg == TRY_BITS'(NR_SEARCH_LIMIT));
        status.t_one     = (t_reg == word_t'(1));
        status.tt_one    = (tt_reg == word_t'(1));
        status.i_lt_m    = (i_reg < m_reg);
        status.j_lt_m    = (j_reg < m_reg);
        status.out_busy  = rsp_valid_reg;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// File: rtl/msqrt_ctrl.sv
// -----------------------------------------------------------------------------
// msqrt_ctrl
// Sequencer for reduction, exponentiation, non-residue search and the
// Tonelli-Shanks rounds.
// -----------------------------------------------------------------------------
module msqrt_ctrl
    import msqrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    input  status_t status,
    output logic    req_stall,
    output cmd_t    cmd
);

    state_t   state_reg;
    state_t   state_next;
    state_t   ret_reg;
    state_t   ret_next;
    res_sel_t res_reg;
    res_sel_t res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            res_reg   <= RES_ZERO_NO;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            res_reg   <= res_next;
        end
    end

    // Next state. The exponentiation loop returns to the state held in ret_reg.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CHECK_P;
                end
            end
            S_CHECK_P:
            begin
                if (status.p_zero)
                begin
                    res_next   = RES_ZERO_NO;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_RED_A_W;
                end
            end
            S_RED_A_W:
            begin
                if (status.red_done)
                begin
                    state_next = S_CHECK_R;
                end
            end
            S_CHECK_R:
            begin
                if (status.r_zero)
                begin
                    res_next   = RES_ZERO_YES;
                    state_next = S_RESULT;
                end
                else if (status.p_two)
                begin
                    res_next   = RES_LOWBIT;
                    state_next = S_RESULT;
                end
                else
                begin
                    ret_next   = S_EULER;
                    state_next = S_POW;
                end
            end
            S_POW:
            begin
                if (status.exp_zero)
                begin
                    state_next = ret_reg;
                end
                else if (status.exp_lsb)
                begin
                    state_next = S_POW_MW;
                end
                else
                begin
                    state_next = S_POW_SW;
                end
            end
            S_POW_MW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_POW_SQ;
                end
            end
            S_POW_SQ:
            begin
                state_next = S_POW_SW;
            end
            S_POW_SW:
            begin
                if (status.mul_done)
                begin
                    state_next = S_POW;
                end
            end
            S_EULER:
            begin
                if (!status.acc_one)
                begin
                    res_next   = RES_ZERO_NO;
                    state_next = S_RESULT;
                end
                else if (status.p_mod4_3)
                begin
                    ret_next   = S_FIN_ACC;
                    state_next = S_POW;
                end
                else
                begin
                    state_next = S_QLOOP;
                end
            end
            S_FIN_ACC:
            begin
                res_next   = RES_ACC;
                state_next = S_RESULT;
            end
            S_QLOOP:
            begin
                if (!status.q_even)
                begin
                    state_next = S_ZTRY;
                end
            end
            S_ZTRY:
            begin
                if (status.tries_max)
                begin
                    res_next   = RES_ZERO_NO;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_ZRED;
                end
            end
            S_ZRED:
            begin
                if (status.red_done)
                begin
                    state_next = S_ZPOW;
                end
            end
            S_ZPOW:
            begin
                ret_next   = S_ZCHK;
                state_next = S_POW;
            end
            S_ZCHK:
            begin
                if (status.acc_pm1)
                begin
                    ret_next   = S_SAVE_C;
                    state_next = S_POW;
                end
                else
                begin
                    state_next = S_ZTRY;
                end
            end
            S_SAVE_C:
            begin
                state_next = S_TPOW;
            end
            S_TPOW:
            begin
                ret_next   = S_SAVE_T;
                state_next = S_POW;
            end
            S_SAVE_T:
            begin
                state_next = S_RPOW;
            end
            S_RPOW:
            begin
                ret_next   = S_SAVE_ROOT;
                state_next = S_POW;
            end
            S_SAVE_ROOT:
            begin
                state_next = S_TS_INIT;
            end
            S_TS_INIT:
            begin
                state_next = S_TS_LOOP;
            end
            S_TS_LOOP:
            begin
                if (status.t_one)
                begin
                    res_next   = RES_ROOT;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                if (!status.i_lt_m)
                begin
                    res_next   = RES_ZERO_NO;
                    state_next = S_RESULT;
                end
                else if (status.tt_one)
                begin
                    state_next = S_BSQ;
                end
                else
                begin
                    state_next = S_ORD_W;
                end
            end
            S_ORD_W:
            begin
                if (status.mul_done)
                begin
                    state_next = S_ORD;
                end
            end
            S_BSQ:
            begin
                state_next = status.j_lt_m ? S_BSQ_W : S_C_SQ;
            end
            S_BSQ_W:
            begin
                if (status.mul_done)
                begin
                    state_next = S_BSQ;
                end
            end
            S_C_SQ:
            begin
                state_next = S_C_W;
            end
            S_C_W:
            begin
                if (status.mul_done)
                begin
                    state_next = S_T_MUL;
                end
            end
            S_T_MUL:
            begin
                state_next = S_T_W;
            end
            S_T_W:
            begin
                if (status.mul_done)
                begin
                    state_next = S_R_MUL;
                end
            end
            S_R_MUL:
            begin
                state_next = S_R_W;
            end
            S_R_W:
            begin
                if (status.mul_done)
                begin
                    state_next = S_TS_LOOP;
                end
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        req_stall    = 1'b1;
        cmd.op       = OP_NONE;
        cmd.mul_x    = SEL_ACC;
        cmd.mul_y    = SEL_BASE;
        cmd.dst      = SEL_ACC;
        cmd.pow_base = BASE_R;
        cmd.pow_exp  = EXP_HALF;
        cmd.res      = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_CHECK_P:
            begin
                if (!status.p_zero)
                begin
                    cmd.op = OP_RED_A;
                end
            end
            S_CHECK_R:
            begin
                if (!status.r_zero && !status.p_two)
                begin
                    cmd.op = OP_POW_INIT;
                end
            end
            S_POW:
            begin
                if (!status.exp_zero)
                begin
                    cmd.op = OP_MUL;
                    if (status.exp_lsb)
                    begin
                        cmd.mul_x = SEL_ACC;
                        cmd.dst   = SEL_ACC;
                    end
                    else
                    begin
                        cmd.mul_x = SEL_BASE;
                        cmd.dst   = SEL_BASE;
                    end
                end
            end
            S_POW_SQ:
            begin
                cmd.op    = OP_MUL;
                cmd.mul_x = SEL_BASE;
                cmd.dst   = SEL_BASE;
            end
            S_POW_SW:
            begin
                if (status.mul_done)
                begin
                    cmd.op = OP_POW_SHIFT;
                end
            end
            S_EULER:
            begin
                if (status.acc_one)
                begin
                    if (status.p_mod4_3)
                    begin
                        cmd.op      = OP_POW_INIT;
                        cmd.pow_exp = EXP_P34;
                    end
                    else
                    begin
                        cmd.op = OP_Q_INIT;
                    end
                end
            end
            S_QLOOP:
            begin
                cmd.op = status.q_even ? OP_Q_SHIFT : OP_Z_INIT;
            end
            S_ZTRY:
            begin
                if (!status.tries_max)
                begin
                    cmd.op = OP_RED_Z;
                end
            end
            S_ZPOW:
            begin
                cmd.op       = OP_POW_INIT;
                cmd.pow_base = BASE_Z;
            end
            S_ZCHK:
            begin
                if (status.acc_pm1)
                begin
                    cmd.op       = OP_POW_INIT;
                    cmd.pow_base = BASE_Z;
                    cmd.pow_exp  = EXP_Q;
                end
                else
                begin
                    cmd.op = OP_Z_NEXT;
                end
            end
            S_SAVE_C:
            begin
                cmd.op  = OP_SAVE;
                cmd.dst = SEL_C;
            end
            S_TPOW:
            begin
                cmd.op      = OP_POW_INIT;
                cmd.pow_exp = EXP_Q;
            end
            S_SAVE_T:
            begin
                cmd.op  = OP_SAVE;
                cmd.dst = SEL_T;
            end
            S_RPOW:
            begin
                cmd.op      = OP_POW_INIT;
                cmd.pow_exp = EXP_Q1;
            end
            S_SAVE_ROOT:
            begin
                cmd.op  = OP_SAVE;
                cmd.dst = SEL_ROOT;
            end
            S_TS_INIT:
            begin
                cmd.op = OP_M_FROM_S;
            end
            S_TS_LOOP:
            begin
                if (!status.t_one)
                begin
                    cmd.op = OP_TT_INIT;
                end
            end
            S_ORD:
            begin
                if (status.i_lt_m)
                begin
                    if (status.tt_one)
                    begin
                        cmd.op = OP_B_INIT;
                    end
                    else
                    begin
                        cmd.op    = OP_MUL;
                        cmd.mul_x = SEL_TT;
                        cmd.mul_y = SEL_TT;
                        cmd.dst   = SEL_TT;
                    end
                end
            end
            S_ORD_W:
            begin
                if (status.mul_done)
                begin
                    cmd.op = OP_I_INC;
                end
            end
            S_BSQ:
            begin
                if (status.j_lt_m)
                begin
                    cmd.op    = OP_MUL;
                    cmd.mul_x = SEL_B;
                    cmd.mul_y = SEL_B;
                    cmd.dst   = SEL_B;
                end
                else
                begin
                    cmd.op = OP_M_SET;
                end
            end
            S_BSQ_W:
            begin
                if (status.mul_done)
                begin
                    cmd.op = OP_J_INC;
                end
            end
            S_C_SQ:
            begin
                cmd.op    = OP_MUL;
                cmd.mul_x = SEL_B;
                cmd.mul_y = SEL_B;
                cmd.dst   = SEL_C;
            end
            S_T_MUL:
            begin
                cmd.op    = OP_MUL;
                cmd.mul_x = SEL_T;
                cmd.mul_y = SEL_C;
                cmd.dst   = SEL_T;
            end
            S_R_MUL:
            begin
                cmd.op    = OP_MUL;
                cmd.mul_x = SEL_ROOT;
                cmd.mul_y = SEL_B;
                cmd.dst   = SEL_ROOT;
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.op = OP_RESULT;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/modular_square_root.sv
// -----------------------------------------------------------------------------
// The run time per item is data dependent, and longer for Tonelli-Shanks than for p = 3 mod 4.
// Requests: one item at a time; req_stall stays high outside the idle state.
// Reset: rst_n clears the sequencer and the result valid at once.
// -----------------------------------------------------------------------------
module modular_square_root
    import msqrt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t    cmd;
    status_t status;

    msqrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    msqrt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .rsp_stall (rsp_stall),
        .status    (status),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

endmodule

// File: rtl/msqrt_checker.sv
// -----------------------------------------------------------------------------
// msqrt_checker
// Port-level checks on the modular square root, bound to the top level.
// -----------------------------------------------------------------------------
`include "modular_square_root_assert.svh"

module msqrt_checker
    import msqrt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    `MSQRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `MSQRT_ASSERT_SAME(a_no_root_zero, rsp_valid && !rsp.is_residue, rsp.root == '0)
    `MSQRT_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
    `MSQRT_ASSERT_NEXT(a_rsp_single, rsp_valid && !rsp_stall, !rsp_valid)

endmodule

bind modular_square_root msqrt_checker u_msqrt_checker (.*);

// File: test/modular_square_root_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular square root testbench
// A table of directed requests comes first, followed by random primes and
// composites. Every response is checked against the table's typed expectation
// or a behavioral square-root predictor, with random gaps on the request side
// and random stalls on the response side.
// ----------------------------------------------------------------------------
module modular_square_root_test;
    import msqrt_pkg::*;

    localparam int NR_TRIES = 4096;
    localparam int RANDOM_REQUESTS = 80;

    typedef longint unsigned u64_t;

    typedef struct {
        logic [31:0] value;
        logic [31:0] modulus;
        bit          typed;
        logic [31:0] root;
        logic        is_residue;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    rsp_t expected_roots[$];
    int   errors = 0;
    int   checked = 0;
    int   residues_seen = 0;
    int   stall_left = 0;
    bit   calm = 1'b0;

    modular_square_root u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic u64_t mulmod(u64_t x, u64_t y, u64_t m);
        return ((x % m) * (y % m)) % m;
    endfunction

    function automatic u64_t powmod(u64_t b, u64_t e, u64_t m);
        u64_t acc;
        acc = 1;
        b = b % m;
        while (e != 0)
        begin
            if (e[0])
                acc = mulmod(acc, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
        end
        return acc % m;
    endfunction

    function automatic rsp_t make_rsp(u64_t root, logic flag);
        rsp_t res;
        res.root = root[31:0];
        res.is_residue = flag;
        return res;
    endfunction

    function automatic rsp_t predict_sqrt(logic [31:0] value, logic [31:0] modulus);
        u64_t p, r, q, s, z, m, c, t, x, i, tt, b, j;
        bit found;
        p = modulus;
        if (p == 0)
            return make_rsp(0, 1'b0);
        r = value % p;
        if (r == 0)
            return make_rsp(0, 1'b1);
        if (p == 2)
            return make_rsp(r & 1, 1'b1);
        if (powmod(r, (p - 1) >> 1, p) != 1)
            return make_rsp(0, 1'b0);
        if ((p & 3) == 3)
            return make_rsp(powmod(r, (p >> 2) + 1, p), 1'b1);
        q = p - 1;
        s = 0;
        while (q[0] == 1'b0)
        begin
            q = q >> 1;
            s++;
        end
        found = 1'b0;
        z = 2;
        for (int k = 0; k < NR_TRIES; k++)
        begin
            if (powmod(z, (p - 1) >> 1, p) == p - 1)
            begin
                found = 1'b1;
                break;
            end
            z++;
        end
        if (!found)
            return make_rsp(0, 1'b0);
        m = s;
        c = powmod(z, q, p);
        t = powmod(r, q, p);
        x = powmod(r, (q + 1) >> 1, p);
        while (t != 1)
        begin
            i = 0;
            tt = t;
            while (tt != 1 && i < m)
            begin
                tt = mulmod(tt, tt, p);
                i++;
            end
            if (tt != 1 || i >= m)
                return make_rsp(0, 1'b0);
            b = c;
            for (j = i + 1; j < m; j++)
                b = mulmod(b, b, p);
            m = i;
            c = mulmod(b, b, p);
            t = mulmod(t, c, p);
            x = mulmod(x, b, p);
        end
        return make_rsp(x, 1'b1);
    endfunction

    function automatic bit check_prime(u64_t n);
        if (n < 2)
            return 1'b0;
        if (n < 4)
            return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        for (u64_t d = 3; d * d <= n; d += 2)
            if (n % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [31:0] random_prime(int unsigned lo, int unsigned hi);
        logic [31:0] n;
        do
            n = $urandom_range(hi, lo) | 32'd1;
        while (!check_prime(n));
        return n;
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // The request stays up when the next one follows without a gap, so valid
    // is never lowered and raised within the same step.
    task automatic send_request(logic [31:0] value, logic [31:0] modulus, int gap,
                                bit typed, rsp_t typed_rsp);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req.value <= value;
        req.modulus <= modulus;
        do
            @(posedge clk);
        while (req_stall);
        expected_roots.push_back(typed ? typed_rsp : predict_sqrt(value, modulus));
    endtask

    // Response side: check and draw a new stall length per response. The
    // stall only counts down while a response is waiting.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_roots.size() == 0)
                begin
                    $display("%0t: response with nothing pending: root %h flag %b",
                             $time, rsp.root, rsp.is_residue);
                    errors++;
                end
                else
                begin
                    rsp_t want;
                    want = expected_roots.pop_front();
                    checked++;
                    if (want.is_residue)
                        residues_seen++;
                    if (rsp.root !== want.root)
                    begin
                        $display("%0t: root expected %h actual %h", $time, want.root,
                                 rsp.root);
                        errors++;
                    end
                    if (rsp.is_residue !== want.is_residue)
                    begin
                        $display("%0t: is_residue expected %b actual %b", $time,
                                 want.is_residue, rsp.is_residue);
                        errors++;
                    end
                end
                stall_left = draw_wait();
            end
            else if (rsp_valid && stall_left > 0)
                stall_left--;
            rsp_stall <= (stall_left != 0);
        end
    end

    initial
    begin
        row_t rows[$];
        rsp_t typed_rsp;
        logic [31:0] p, v, x;
        int pick;
        u64_t sq;

        // Value, modulus, typed expectation, root, flag.
        rows.push_back('{32'd5, 32'd0, 1, 32'd0, 1'b0});
        rows.push_back('{32'hFFFFFFFF, 32'd0, 1, 32'd0, 1'b0});
        rows.push_back('{32'hFFFFFFFF, 32'd1, 1, 32'd0, 1'b1});
        rows.push_back('{32'd0, 32'd7, 1, 32'd0, 1'b1});
        rows.push_back('{32'd21, 32'd7, 1, 32'd0, 1'b1});
        rows.push_back('{32'hFFFFFFFF, 32'd2, 1, 32'd1, 1'b1});
        rows.push_back('{32'hFFFFFFFE, 32'd2, 1, 32'd0, 1'b1});
        rows.push_back('{32'd3, 32'd7, 1, 32'd0, 1'b0});
        rows.push_back('{32'd2, 32'd7, 0, 32'd0, 1'b0});
        rows.push_back('{32'd1, 32'd3, 1, 32'd1, 1'b1});
        rows.push_back('{32'd2, 32'd3, 1, 32'd0, 1'b0});
        rows.push_back('{32'd10, 32'd13, 0, 32'd0, 1'b0});
        rows.push_back('{32'd3, 32'd17, 0, 32'd0, 1'b0});
        rows.push_back('{32'd2, 32'd65537, 0, 32'd0, 1'b0});
        rows.push_back('{32'hFFFFFFFF, 32'd4294967291, 0, 32'd0, 1'b0});
        rows.push_back('{32'd4294967290, 32'd4294967291, 0, 32'd0, 1'b0});
        rows.push_back('{32'd9, 32'd3221225473, 0, 32'd0, 1'b0});
        rows.push_back('{32'd123456789, 32'd2013265921, 0, 32'd0, 1'b0});
        rows.push_back('{32'hFFFFFFFF, 32'd3221225473, 0, 32'd0, 1'b0});
        rows.push_back('{32'd4, 32'd15, 0, 32'd0, 1'b0});
        rows.push_back('{32'd7, 32'd15, 0, 32'd0, 1'b0});
        // Composite modulus where no non-residue turns up within the search.
        rows.push_back('{32'd1, 32'd21, 1, 32'd0, 1'b0});
        rows.push_back('{32'h80000000, 32'hFFFFFFFF, 0, 32'd0, 1'b0});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[k])
        begin
            typed_rsp.root = rows[k].root;
            typed_rsp.is_residue = rows[k].is_residue;
            send_request(rows[k].value, rows[k].modulus, draw_wait(), rows[k].typed,
                         typed_rsp);
        end

        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k % 25 == 0)
                calm = ($urandom_range(0, 2) == 0);
            v = $urandom;
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3:
                    p = random_prime(3, 32'hFFFFFFFF);
                4, 5:
                    p = random_prime(3, 2000);
                6:
                begin
                    case ($urandom_range(0, 3))
                        0: p = 32'd3221225473;
                        1: p = 32'd2013265921;
                        2: p = 32'd65537;
                        default: p = 32'd998244353;
                    endcase
                end
                7:
                begin
                    p = $urandom_range(0, 1) ? 32'd2 : random_prime(3, 32'hFFFF);
                    if ($urandom_range(0, 1))
                        v = p * $urandom_range(0, 32'hFFFFFFFF / p);
                end
                8:
                    p = $urandom | 32'd3;
                default:
                    p = random_prime(32'h80000000, 32'hFFFFFFFF);
            endcase
            // Most requests carry a true square so the full root search runs.
            if (pick != 7 && pick != 8 && p > 2 && $urandom_range(0, 2) != 0)
            begin
                x = $urandom;
                sq = mulmod(x, x, p);
                v = sq[31:0];
            end
            send_request(v, p, draw_wait(), 1'b0, typed_rsp);
        end
        req_valid <= 1'b0;

        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Checked %0d responses, %0d of them with a root; %0d errors.",
                 checked, residues_seen, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #300ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
